@@ src/indexed_ordered_list_engine_assert.svh @@
// Assertion macros for the list engine checker.
`ifndef INDEXED_ORDERED_LIST_ENGINE_ASSERT_SVH
`define INDEXED_ORDERED_LIST_ENGINE_ASSERT_SVH

// Same-cycle implication, sampled on clk and quiet while rst_n is low.
`define ILE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and quiet while rst_n is low.
`define ILE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/ile_pkg.sv @@
// Types and codes for the indexed ordered list engine.
package ile_pkg;

  localparam int OP_W    = 3;
  localparam int VAL_W   = 32;
  localparam int POS_W   = 7;
  localparam int FPOS_W  = 8;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 7;

  localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_INS_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_INS_AT    = 3'd2;
  localparam logic [OP_W-1:0] OP_RM_FRONT  = 3'd3;
  localparam logic [OP_W-1:0] OP_RM_BACK   = 3'd4;
  localparam logic [OP_W-1:0] OP_RM_AT     = 3'd5;
  localparam logic [OP_W-1:0] OP_READ_AT   = 3'd6;
  localparam logic [OP_W-1:0] OP_FIND      = 3'd7;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_INVAL = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  localparam logic [VAL_W-1:0]  VAL_MISS = '1;
  localparam logic [FPOS_W-1:0] POS_MISS = '1;

  typedef struct packed {
    logic [OP_W-1:0]         operation;
    logic signed [VAL_W-1:0] element_value;
    logic [POS_W-1:0]        position;
  } ile_in_t;

  typedef struct packed {
    logic signed [VAL_W-1:0]  result_value;
    logic signed [FPOS_W-1:0] found_position;
    logic [STAT_W-1:0]        status;
    logic [COUNT_W-1:0]       entry_count;
  } ile_out_t;

endpackage

@@ src/indexed_ordered_list_engine.sv @@
// Indexed ordered list engine: one request at a time, with busy high until it finishes.
// Insert shifts the tail up (append does not), remove shifts it down, read fetches one entry,
// find scans from the front. The next request is taken in the result beat's cycle.
// Invalid and full requests go straight to the result step. The result strobe lasts one cycle.
// Reset (rst_n low, synchronous) empties the list; stored words keep no reset value.
module indexed_ordered_list_engine #(
  parameter int CAPACITY = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  ile_pkg::ile_in_t in_item,
  output logic             out_valid,
  output ile_pkg::ile_out_t out_item
);
  import ile_pkg::*;

  // Count must reach CAPACITY itself; memory index only CAPACITY-1.
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);
  // Common width for comparing position with count and for masked outputs.
  localparam int EXT_W = ((CNT_W > FPOS_W) ? CNT_W : FPOS_W) + 1;
  localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] ONE_C = CNT_W'(1);

  // Sequencer states.
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_UP    = 3'd1; // stream tail upwards, highest entry first
  localparam logic [2:0] S_DN    = 3'd2; // read the hole, then stream tail downwards
  localparam logic [2:0] S_FIND  = 3'd3; // scan from the front for the first match
  localparam logic [2:0] S_DRAIN = 3'd4; // let the last read in flight land
  localparam logic [2:0] S_FIN   = 3'd5; // place inserted value, update count, report

  // What the memory word arriving this cycle is for.
  localparam logic [1:0] TAG_NONE = 2'd0;
  localparam logic [1:0] TAG_WB   = 2'd1; // write it back at tag_addr_r
  localparam logic [1:0] TAG_CAP  = 2'd2; // it is the result value
  localparam logic [1:0] TAG_CMP  = 2'd3; // compare it with the search value

  logic [VAL_W-1:0] mem [CAPACITY];

  logic [2:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [OP_W-1:0]   op_r, op_nxt;
  logic [VAL_W-1:0]  val_r, val_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic [CNT_W-1:0]  end_r, end_nxt;
  logic [CNT_W-1:0]  ptr_r, ptr_nxt;
  logic [1:0]        tag_r, tag_nxt;
  logic [CNT_W-1:0]  tag_addr_r, tag_addr_nxt;
  logic [VAL_W-1:0]  rdata_r;
  logic [VAL_W-1:0]  res_val_r, res_val_nxt;
  logic [FPOS_W-1:0] fp_r, fp_nxt;
  logic [STAT_W-1:0] st_r, st_nxt;
  logic              out_valid_r, out_valid_nxt;
  ile_out_t          out_item_r, out_item_nxt;

  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [VAL_W-1:0]  wr_data;

  logic [EXT_W-1:0]  pos_e;
  logic [EXT_W-1:0]  cnt_e;
  logic [POS_W-1:0]  pos_m1;
  logic [EXT_W-1:0]  fp_e;
  logic [EXT_W-1:0]  cnt_out_e;
  logic              is_ins;
  logic              is_rm;

  assign pos_e   = EXT_W'(in_item.position);
  assign cnt_e   = EXT_W'(cnt_r);
  assign pos_m1  = in_item.position - POS_W'(1);
  assign fp_e    = EXT_W'(tag_addr_r) + EXT_W'(1);
  assign is_ins  = (op_r == OP_INS_FRONT) || (op_r == OP_INS_BACK) || (op_r == OP_INS_AT);
  assign is_rm   = (op_r == OP_RM_FRONT) || (op_r == OP_RM_BACK) || (op_r == OP_RM_AT);

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    op_nxt        = op_r;
    val_nxt       = val_r;
    idx_nxt       = idx_r;
    end_nxt       = end_r;
    ptr_nxt       = ptr_r;
    tag_nxt       = TAG_NONE;
    tag_addr_nxt  = tag_addr_r;
    res_val_nxt   = res_val_r;
    fp_nxt        = fp_r;
    st_nxt        = st_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    rd_en         = 1'b0;
    rd_addr       = ptr_r[IDX_W-1:0];
    wr_en         = 1'b0;
    wr_addr       = tag_addr_r[IDX_W-1:0];
    wr_data       = rdata_r;
    cnt_out_e     = cnt_e;

    // Retire the word read last cycle.
    case (tag_r)
      TAG_WB:  wr_en = 1'b1;
      TAG_CAP: res_val_nxt = rdata_r;
      default: ;
    endcase

    case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt      = in_item.operation;
          val_nxt     = in_item.element_value;
          res_val_nxt = '0;
          fp_nxt      = '0;
          st_nxt      = ST_OK;
          ptr_nxt     = '0;
          state_nxt   = S_FIN;
          case (in_item.operation)
            OP_INS_FRONT, OP_INS_BACK, OP_INS_AT: begin
              if (in_item.operation == OP_INS_FRONT) begin
                idx_nxt = '0;
              end else if (in_item.operation == OP_INS_BACK) begin
                idx_nxt = cnt_r;
              end else begin
                idx_nxt = CNT_W'(pos_m1);
              end
              // Position check takes priority over fullness.
              if ((in_item.operation == OP_INS_AT) &&
                  ((pos_e == '0) || (pos_e > cnt_e + EXT_W'(1)))) begin
                st_nxt = ST_INVAL;
              end else if (cnt_r >= CAP_C) begin
                st_nxt = ST_FULL;
              end else if (idx_nxt != cnt_r) begin
                ptr_nxt   = cnt_r - ONE_C;
                state_nxt = S_UP;
              end
            end
            OP_RM_FRONT, OP_RM_BACK, OP_RM_AT, OP_READ_AT: begin
              if (in_item.operation == OP_RM_FRONT) begin
                idx_nxt = '0;
              end else if (in_item.operation == OP_RM_BACK) begin
                idx_nxt = cnt_r - ONE_C;
              end else begin
                idx_nxt = CNT_W'(pos_m1);
              end
              if ((in_item.operation == OP_RM_FRONT) || (in_item.operation == OP_RM_BACK)) begin
                if (cnt_r == '0) begin
                  st_nxt = ST_INVAL;
                end
              end else if ((pos_e == '0) || (pos_e > cnt_e)) begin
                st_nxt = ST_INVAL;
              end
              if (st_nxt == ST_OK) begin
                ptr_nxt   = idx_nxt;
                // A read only fetches the one entry; a remove closes the gap.
                end_nxt   = (in_item.operation == OP_READ_AT) ? idx_nxt : cnt_r - ONE_C;
                state_nxt = S_DN;
              end else if (in_item.operation == OP_READ_AT) begin
                res_val_nxt = VAL_MISS;
              end
            end
            default: begin
              fp_nxt = POS_MISS;
              st_nxt = ST_INVAL;
              if (cnt_r != '0) begin
                state_nxt = S_FIND;
              end
            end
          endcase
        end
      end

      S_UP: begin
        rd_en        = 1'b1;
        tag_nxt      = TAG_WB;
        tag_addr_nxt = ptr_r + ONE_C;
        if (ptr_r == idx_r) begin
          state_nxt = S_DRAIN;
        end else begin
          ptr_nxt = ptr_r - ONE_C;
        end
      end

      S_DN: begin
        rd_en        = 1'b1;
        tag_nxt      = (ptr_r == idx_r) ? TAG_CAP : TAG_WB;
        tag_addr_nxt = ptr_r - ONE_C;
        if (ptr_r == end_r) begin
          state_nxt = S_DRAIN;
        end else begin
          ptr_nxt = ptr_r + ONE_C;
        end
      end

      S_FIND: begin
        if ((tag_r == TAG_CMP) && (rdata_r == val_r)) begin
          fp_nxt    = fp_e[FPOS_W-1:0];
          st_nxt    = ST_OK;
          state_nxt = S_FIN;
        end else if (ptr_r != cnt_r) begin
          rd_en        = 1'b1;
          tag_nxt      = TAG_CMP;
          tag_addr_nxt = ptr_r;
          ptr_nxt      = ptr_r + ONE_C;
        end else if (tag_r != TAG_CMP) begin
          state_nxt = S_FIN;
        end
      end

      S_DRAIN: begin
        state_nxt = S_FIN;
      end

      S_FIN: begin
        if (st_r == ST_OK) begin
          if (is_ins) begin
            wr_en   = 1'b1;
            wr_addr = idx_r[IDX_W-1:0];
            wr_data = val_r;
            cnt_nxt = cnt_r + ONE_C;
          end else if (is_rm) begin
            cnt_nxt = cnt_r - ONE_C;
          end
        end
        cnt_out_e                   = EXT_W'(cnt_nxt);
        out_item_nxt.result_value   = res_val_r;
        out_item_nxt.found_position = fp_r;
        out_item_nxt.status         = st_r;
        out_item_nxt.entry_count    = cnt_out_e[COUNT_W-1:0];
        out_valid_nxt               = 1'b1;
        state_nxt                   = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Value store: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      tag_r       <= TAG_NONE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      tag_r       <= tag_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Request and result payload: hold, no reset.
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    val_r      <= val_nxt;
    idx_r      <= idx_nxt;
    end_r      <= end_nxt;
    ptr_r      <= ptr_nxt;
    tag_addr_r <= tag_addr_nxt;
    res_val_r  <= res_val_nxt;
    fp_r       <= fp_nxt;
    st_r       <= st_nxt;
    out_item_r <= out_item_nxt;
  end

endmodule

@@ src/ile_checker.sv @@
// Port-level checker for the list engine, bound to the top level.
`include "indexed_ordered_list_engine_assert.svh"

module ile_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_valid,
  input ile_pkg::ile_out_t out_item
);
  import ile_pkg::*;

  logic accept;
  logic full_flag;

  assign accept    = start && !busy;
  assign full_flag = out_valid && (out_item.status == ST_FULL);

  `ILE_ASSERT_NXT(a_accept_busy, accept, busy, "engine not busy after a taken request")
  `ILE_ASSERT_IMP(a_beat_idle, out_valid, !busy, "result beat while still busy")
  `ILE_ASSERT_IMP(a_done_beat, $fell(busy), out_valid, "request finished without a beat")
  `ILE_ASSERT_NXT(a_single_beat, out_valid, !out_valid, "result beat held for two cycles")
  `ILE_ASSERT_IMP(a_full_nonzero, full_flag, out_item.entry_count != '0 || busy,
                  "store reported full while empty")

endmodule

bind indexed_ordered_list_engine ile_checker u_ile_checker (.*);
